// ===== src/pmpe_pkg.sv =====
// Shared types and constants for the plus/minus/parenthesis expression evaluator.
package pmpe_pkg;

  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned CHAR_W         = 8;
  localparam int unsigned NEST_DEPTH_DEF = 16;

  localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;  // '('
  localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;  // ')'
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;  // '9'

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              end_of_expr;
  } in_beat_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      error;
  } out_beat_t;

  // One saved nesting level: the outer total and the sign applied to the sub-sum.
  typedef struct packed {
    logic [VALUE_W-1:0] total;
    logic               sign;
  } nest_entry_t;

  localparam int unsigned NEST_ENTRY_W = $bits(nest_entry_t);

endpackage

// ===== src/pmpe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pmpe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/plus_minus_paren_expression_evaluator_unit.sv =====
// Top level of the streaming plus/minus/parenthesis expression evaluator.
// The block reads an infix expression one ASCII character per input beat and, on the beat
// flagged end_of_expr, delivers one result beat holding the 32-bit wrapped value and an error
// flag, then starts afresh. It takes one character every clock cycle unless stalled: each beat
// lands in an input register, and in the following cycle a single pass of logic (one
// shift-and-add for the decimal accumulator, one add to fold the number into the running total
// and one more add on a close parenthesis) updates the state. A result is loaded into the output
// register at the same edge at which its last character leaves the input register, so it passes
// through the input register and then the output register. The input only stalls when a final
// character meets a result beat that the receiver is still stalling.
// Open parentheses save the outer total and sign in a stack of NEST_DEPTH entries. The entry on
// top is held in a register and the rest in a small RAM whose read port always prefetches the
// entry just below the top, so a close parenthesis never waits for memory. No clearing pass is
// needed after reset. Digits accumulate modulo 2^32, characters other than digits, '+', '-',
// '(' and ')' are ignored, and opening past NEST_DEPTH levels or closing at level zero sets
// the error flag, as does an expression that ends with parentheses still open.
module plus_minus_paren_expression_evaluator_unit #(
  parameter int unsigned NEST_DEPTH = pmpe_pkg::NEST_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  pmpe_pkg::in_beat_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pmpe_pkg::out_beat_t out_data
);

  import pmpe_pkg::*;

  localparam int unsigned LVL_W  = $clog2(NEST_DEPTH + 1);
  localparam int unsigned ADDR_W = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

  // Input register.
  logic     in_q_valid;
  in_beat_t in_q;

  // Evaluation state.
  logic [VALUE_W-1:0] running_total;
  logic               pending_sign;
  logic [VALUE_W-1:0] number_accum;
  logic [LVL_W-1:0]   nest_level;
  logic               error_seen;
  nest_entry_t        nest_top;

  logic [VALUE_W-1:0] running_total_next;
  logic               pending_sign_next;
  logic [VALUE_W-1:0] number_accum_next;
  logic [LVL_W-1:0]   nest_level_next;
  logic               error_seen_next;

  // Combinational work on the character in the input register.
  logic               proc;
  logic               is_digit;
  logic               other_char;
  logic [VALUE_W-1:0] digit_val;
  logic [VALUE_W-1:0] accum_ten;
  logic [VALUE_W-1:0] accum_term;
  logic [VALUE_W-1:0] committed;
  logic [VALUE_W-1:0] popped_term;
  logic [VALUE_W-1:0] digit_final;
  logic [VALUE_W-1:0] result_value;
  logic               result_error;
  logic               push;
  logic               pop;
  logic               push_ok;

  // Stack RAM signals.
  nest_entry_t        push_entry;
  logic [NEST_ENTRY_W-1:0] below_raw;
  nest_entry_t        nest_below;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [LVL_W-1:0]   below_level;

  // A beat is processed unless it would produce a result while the output is still held.
  assign proc     = in_q_valid && !(in_q.end_of_expr && out_valid && out_stall);
  assign in_stall = in_q_valid && !proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_q_valid <= 1'b1;
    end else if (proc) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
  end

  assign is_digit  = (in_q.char_code >= CH_ZERO) && (in_q.char_code <= CH_NINE);
  assign digit_val = VALUE_W'(in_q.char_code[3:0]);
  // acc * 10 + digit as (acc << 3) + (acc << 1) + digit, wrapping at 32 bits.
  assign accum_ten = {number_accum[VALUE_W-4:0], 3'b000}
                   + {number_accum[VALUE_W-2:0], 1'b0} + digit_val;
  assign accum_term = pending_sign ? (VALUE_W'(0) - number_accum) : number_accum;
  assign committed  = running_total + accum_term;
  assign popped_term = nest_top.sign ? (VALUE_W'(0) - committed) : committed;
  assign digit_final = running_total
                     + (pending_sign ? (VALUE_W'(0) - accum_ten) : accum_ten);
  assign push_ok    = nest_level < LVL_W'(NEST_DEPTH);

  always_comb begin
    running_total_next = running_total;
    pending_sign_next  = pending_sign;
    number_accum_next  = number_accum;
    nest_level_next    = nest_level;
    error_seen_next    = error_seen;
    push               = 1'b0;
    pop                = 1'b0;
    other_char         = 1'b0;
    if (is_digit) begin
      number_accum_next = accum_ten;
    end else begin
      case (in_q.char_code)
        CH_PLUS, CH_MINUS: begin
          running_total_next = committed;
          number_accum_next  = '0;
          pending_sign_next  = (in_q.char_code == CH_MINUS);
        end
        CH_OPEN: begin
          number_accum_next = '0;
          if (push_ok) begin
            push               = 1'b1;
            nest_level_next    = nest_level + LVL_W'(1);
            running_total_next = '0;
            pending_sign_next  = 1'b0;
          end else begin
            running_total_next = committed;
            error_seen_next    = 1'b1;
          end
        end
        CH_CLOSE: begin
          number_accum_next = '0;
          if (nest_level == '0) begin
            running_total_next = committed;
            error_seen_next    = 1'b1;
          end else begin
            pop                = 1'b1;
            nest_level_next    = nest_level - LVL_W'(1);
            running_total_next = nest_top.total + popped_term;
            pending_sign_next  = 1'b0;
          end
        end
        default: begin
          other_char = 1'b1;
        end
      endcase
    end
    // A digit or an ignored character can leave a number pending, so the final commit folds
    // it in then. Operators and parentheses have already folded theirs.
    if (is_digit) begin
      result_value = digit_final;
    end else if (other_char) begin
      result_value = committed;
    end else begin
      result_value = running_total_next;
    end
    result_error = error_seen_next || (nest_level_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_total <= '0;
      pending_sign  <= 1'b0;
      number_accum  <= '0;
      nest_level    <= '0;
      error_seen    <= 1'b0;
    end else if (proc) begin
      if (in_q.end_of_expr) begin
        running_total <= '0;
        pending_sign  <= 1'b0;
        number_accum  <= '0;
        nest_level    <= '0;
        error_seen    <= 1'b0;
      end else begin
        running_total <= running_total_next;
        pending_sign  <= pending_sign_next;
        number_accum  <= number_accum_next;
        nest_level    <= nest_level_next;
        error_seen    <= error_seen_next;
      end
    end
  end

  // The stack. Every pushed entry goes into the RAM at the current level, and a copy is kept
  // in nest_top. The RAM read address follows the next level minus two, so its registered
  // output always holds the entry under the top. That entry was written on an earlier edge,
  // so reads never collide with the write of the same cycle.
  assign push_entry = '{total: committed, sign: pending_sign};
  assign nest_below = nest_entry_t'(below_raw);
  assign ram_waddr  = nest_level[ADDR_W-1:0];

  always_comb begin
    below_level = '0;
    if (proc && !in_q.end_of_expr) begin
      below_level = nest_level_next;
    end else if (!proc) begin
      below_level = nest_level;
    end
    if ({1'b0, below_level} >= (LVL_W + 1)'(2)) begin
      ram_raddr = ADDR_W'(below_level - LVL_W'(2));
    end else begin
      ram_raddr = '0;
    end
  end

  pmpe_ram #(
    .WIDTH (NEST_ENTRY_W),
    .DEPTH (NEST_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (proc && push),
    .waddr (ram_waddr),
    .wdata (push_entry),
    .raddr (ram_raddr),
    .rdata (below_raw)
  );

  always_ff @(posedge clk) begin
    if (proc && push) begin
      nest_top <= push_entry;
    end else if (proc && pop) begin
      nest_top <= nest_below;
    end
  end

  // Output register: loaded by the final character, held while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc && in_q.end_of_expr) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && in_q.end_of_expr) begin
      out_data.value <= signed'(result_value);
      out_data.error <= result_error;
    end
  end

  // The nesting level never passes the stack depth.
  assert property (@(posedge clk) disable iff (rst) nest_level <= LVL_W'(NEST_DEPTH))
    else $error("nest level beyond stack depth");

  // A result beat still being stalled is never overwritten by a new final character.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !(proc && in_q.end_of_expr))
    else $error("pending result overwritten");

  // After the final character the evaluation state is back at its starting point.
  assert property (@(posedge clk) disable iff (rst)
    proc && in_q.end_of_expr |=> nest_level == '0 && number_accum == '0 && !error_seen
                                 && running_total == '0 && !pending_sign)
    else $error("state not cleared after expression end");

  // An accepted push raises the level by exactly one.
  assert property (@(posedge clk) disable iff (rst)
    proc && push && !in_q.end_of_expr |=> nest_level == $past(nest_level) + LVL_W'(1))
    else $error("push did not raise nest level");

  // The input only stalls when a beat is waiting in the input register.
  assert property (@(posedge clk) disable iff (rst) in_stall |-> in_q_valid)
    else $error("stall without a held beat");

endmodule

// ===== dv/pmpe_eval_checker.sv =====
// Checker for the expression evaluator: predicts each result beat and compares it.
`timescale 1ns / 1ps
module pmpe_eval_checker #(
  parameter int unsigned NEST_DEPTH = pmpe_pkg::NEST_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  pmpe_pkg::in_beat_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  pmpe_pkg::out_beat_t out_data,
  output int                  fail_count,
  output int                  results_pending
);

  import pmpe_pkg::*;

  // Predicted evaluator state.
  logic [VALUE_W-1:0] sum_total;
  logic               sum_minus;
  logic [VALUE_W-1:0] num_accum;
  nest_entry_t        paren_stack [NEST_DEPTH];
  int unsigned        paren_level;
  logic               err_flag;

  out_beat_t expected_values[$];
  out_beat_t oldest;

  function automatic logic [VALUE_W-1:0] apply_sign(input logic minus,
                                                    input logic [VALUE_W-1:0] mag);
    return minus ? -mag : mag;
  endfunction

  task automatic clear_state();
    sum_total   = '0;
    sum_minus   = 1'b0;
    num_accum   = '0;
    paren_level = 0;
    err_flag    = 1'b0;
  endtask

  task automatic fold_number();
    sum_total = sum_total + apply_sign(sum_minus, num_accum);
    num_accum = '0;
  endtask

  task automatic eval_char(input in_beat_t b);
    logic [CHAR_W-1:0] c;
    c = b.char_code;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      num_accum = num_accum * 10 + VALUE_W'(c - CH_ZERO);
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      fold_number();
      sum_minus = (c == CH_MINUS);
    end else if (c == CH_OPEN) begin
      fold_number();
      if (paren_level < NEST_DEPTH) begin
        paren_stack[paren_level] = '{total: sum_total, sign: sum_minus};
        paren_level++;
        sum_total = '0;
        sum_minus = 1'b0;
      end else begin
        err_flag = 1'b1;
      end
    end else if (c == CH_CLOSE) begin
      fold_number();
      if (paren_level == 0) begin
        err_flag = 1'b1;
      end else begin
        paren_level--;
        sum_total = paren_stack[paren_level].total
                    + apply_sign(paren_stack[paren_level].sign, sum_total);
        sum_minus = 1'b0;
      end
    end
    if (b.end_of_expr) begin
      fold_number();
      if (paren_level != 0) err_flag = 1'b1;
      expected_values.insert(expected_values.size(), '{value: sum_total, error: err_flag});
      clear_state();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      expected_values.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_values.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result beat, expected none, actual value %0d error %0b",
                   $time, out_data.value, out_data.error);
        end else begin
          oldest = expected_values.pop_front();
          if (out_data.value !== oldest.value) begin
            fail_count++;
            $display("%0t: value mismatch, expected %0d, actual %0d",
                     $time, oldest.value, out_data.value);
          end
          if (out_data.error !== oldest.error) begin
            fail_count++;
            $display("%0t: error flag mismatch, expected %0b, actual %0b",
                     $time, oldest.error, out_data.error);
          end
        end
      end
      if (in_valid && !in_stall) eval_char(in_data);
    end
    results_pending = expected_values.size();
  end

endmodule

// ===== dv/tb_plus_minus_paren_expression_evaluator_unit.sv =====
// Testbench top for the expression evaluator: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps
module tb_plus_minus_paren_expression_evaluator_unit;
  import pmpe_pkg::*;

  localparam int unsigned DEPTH = NEST_DEPTH_DEF;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  in_beat_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_beat_t out_data;

  int fail_count;
  int results_pending;

  // While this is set neither side idles, giving a long back-to-back stretch.
  bit quiet_stretch = 1'b0;
  // Beats that the block actually acts on (ignored characters are not counted unless they end an expression).
  int active_beats  = 0;
  int expr_count    = 0;
  int mode;

  // Characters of the expression being built, sent in order.
  logic [CHAR_W-1:0] expr_chars[$];

  plus_minus_paren_expression_evaluator_unit #(.NEST_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  pmpe_eval_checker #(.NEST_DEPTH(DEPTH)) checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .results_pending(results_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls at random about 11 percent of the time, except in the quiet stretch.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !quiet_stretch && ($urandom_range(0, 99) < 11);
    end
  end

  // Adds one character at the end of the expression being built.
  task automatic append_char(input logic [CHAR_W-1:0] c);
    expr_chars.insert(expr_chars.size(), c);
  endtask

  // A character the block acts on: a digit, an operator or a parenthesis.
  function automatic bit is_active(input logic [CHAR_W-1:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS || c == CH_MINUS
           || c == CH_OPEN || c == CH_CLOSE;
  endfunction

  // Any byte that the block ignores; spaces come up most often.
  function automatic logic [CHAR_W-1:0] pick_ignored();
    logic [CHAR_W-1:0] c;
    if ($urandom_range(0, 1) == 0) return 8'h20;
    do c = CHAR_W'($urandom_range(0, 255)); while (is_active(c));
    return c;
  endfunction

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) append_char(s[i]);
  endtask

  // A decimal number, mostly short; long ones can overflow the 32-bit accumulator.
  // Now and then an ignored character splits the digits, which still join up.
  task automatic push_number();
    int digits;
    digits = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3) : $urandom_range(4, 12);
    for (int i = 0; i < digits; i++) begin
      if (i > 0 && $urandom_range(0, 99) < 8) append_char(pick_ignored());
      append_char(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
    end
  endtask

  // A balanced expression: terms joined by '+' or '-', with random nesting up to
  // max_depth, an occasional leading minus and some stray spaces.
  task automatic push_well_formed(input int max_depth);
    int depth;
    int terms;
    depth = 0;
    terms = $urandom_range(1, 8);
    for (int t = 0; t < terms; t++) begin
      if (t > 0) append_char($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
      else if ($urandom_range(0, 99) < 10) append_char(CH_MINUS);
      if ($urandom_range(0, 99) < 10) append_char(8'h20);
      while (depth < max_depth && $urandom_range(0, 99) < 30) begin
        append_char(CH_OPEN);
        depth++;
        if ($urandom_range(0, 99) < 15) append_char(CH_MINUS);
      end
      push_number();
      while (depth > 0 && $urandom_range(0, 99) < 35) begin
        append_char(CH_CLOSE);
        depth--;
      end
    end
    while (depth > 0) begin
      append_char(CH_CLOSE);
      depth--;
    end
  endtask

  // One input beat. Idle cycles go first; the beat then holds until it is taken.
  // On return the time is the falling edge after acceptance, with valid still high.
  task automatic send_beat(input logic [CHAR_W-1:0] ch, input logic last);
    while (!quiet_stretch && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{char_code: ch, end_of_expr: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (is_active(ch) || last) active_beats++;
  endtask

  // Send the built expression, flagging its last character, then clear it.
  task automatic send_expr();
    foreach (expr_chars[i]) send_beat(expr_chars[i], i == expr_chars.size() - 1);
    expr_chars.delete();
    expr_count++;
  endtask

  // Hold the sender off until every expected result has come back. At least one
  // falling edge passes, so valid never gets two assignments in one step.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_pending != 0);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. An ignored byte with every bit set, alone, gives zero.
    append_char(8'hFF);
    send_expr();
    // The zero byte is ignored too.
    append_char(8'h00);
    send_expr();
    // Both operators and a signed sub-sum: 9 - 15.
    push_str("9-(8+7)");
    send_expr();
    // A close parenthesis with nothing open sets the error flag.
    push_str(")1");
    send_expr();
    // A parenthesis still open at the end sets the error flag.
    push_str("(5");
    send_expr();
    // Ten nines wrap the accumulator.
    push_str("9999999999");
    send_expr();
    // A space between digits joins them into one number.
    push_str("1 2");
    send_expr();
    // An ignored character at the end still lets the pending number count.
    push_str("3-12 ");
    send_expr();
    drain_results();

    // Random part. Mostly balanced expressions with random content; the rest is
    // nesting around the stack depth, broken expressions and plain noise.
    while (active_beats < 1200) begin
      // Both sides run without idling for a long stretch in the middle.
      quiet_stretch <= (active_beats >= 500 && active_beats < 750);
      mode = $urandom_range(0, 99);
      if (mode < 70) begin
        push_well_formed(($urandom_range(0, 99) < 70) ? $urandom_range(0, 3)
                                                      : $urandom_range(4, DEPTH));
      end else if (mode < 78) begin
        // Deep nesting around the stack depth; past it, the extra opens are
        // dropped and the matching closes turn up unmatched.
        int opens;
        opens = $urandom_range(DEPTH - 1, DEPTH + 3);
        for (int i = 0; i < opens; i++) begin
          if ($urandom_range(0, 99) < 30) push_number();
          if (i > 0 || $urandom_range(0, 1)) begin
            append_char($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
          end
          append_char(CH_OPEN);
        end
        push_number();
        for (int i = 0; i < opens; i++) begin
          append_char(CH_CLOSE);
          if ($urandom_range(0, 99) < 30) begin
            append_char($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            push_number();
          end
        end
      end else if (mode < 90) begin
        // A balanced expression with one flaw: an extra parenthesis at either
        // end or anywhere inside, or a character dropped.
        push_well_formed($urandom_range(0, 4));
        case ($urandom_range(0, 3))
          0: expr_chars.push_front(CH_OPEN);
          1: append_char(CH_CLOSE);
          2: if (expr_chars.size() > 1) expr_chars.delete($urandom_range(0, expr_chars.size() - 1));
          default: expr_chars.insert($urandom_range(0, expr_chars.size()),
                                     $urandom_range(0, 1) ? CH_OPEN : CH_CLOSE);
        endcase
      end else begin
        // Noise: any byte at all, or a jumble of the characters that matter.
        int len;
        string jumble;
        jumble = "0123456789+-() ";
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 1)) append_char(CHAR_W'($urandom_range(0, 255)));
          else append_char(jumble[$urandom_range(0, jumble.len() - 1)]);
        end
      end
      send_expr();
      if (expr_count % 40 == 0) drain_results();
    end

    // Wait for the last results, then idle on for anything stray.
    drain_results();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard limit, far beyond the slowest correct run.
  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
